### rtl/ctc_pkg.sv
package ctc_pkg;

  // Fixed sizes of the token scanner.
  localparam int MAX_TOKEN_LEN   = 64;
  localparam int KEYWORD_SLOTS   = 32;
  localparam int MAX_KEYWORD_LEN = 8;
  localparam int PREFIX_W        = 8 * MAX_KEYWORD_LEN;

  // Result queue between the scanner and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Token kinds as they appear on the result word.
  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_OPER    = 3'd3;
  localparam logic [2:0] KIND_SYMBOL  = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [4:0]  keyword_number;
    logic [6:0]  token_length;
    logic [7:0]  token_byte;
    logic [31:0] start_offset;
    logic        last_of_run;
  } out_word_t;

  // One scanned token before keyword lookup. The prefix holds the first
  // bytes of a word, byte 0 in the top bits, zero past the word's end.
  typedef struct packed {
    logic [2:0]          kind;
    logic [6:0]          length;
    logic [7:0]          first;
    logic [31:0]         start;
    logic                last;
    logic [PREFIX_W-1:0] prefix;
  } lex_entry_t;

  // Up to two tokens produced by one accepted byte, in stream order.
  typedef struct packed {
    logic [1:0] count;
    lex_entry_t first;
    lex_entry_t second;
  } push_req_t;

  // Keyword spellings, left aligned and zero padded to the prefix width.
  localparam logic [PREFIX_W-1:0] KEYWORD_TEXT [KEYWORD_SLOTS] = '{
    {"auto", 32'd0},   {"break", 24'd0},  {"case", 32'd0},   {"char", 32'd0},
    {"const", 24'd0},  {"continue"},      {"default", 8'd0}, {"do", 48'd0},
    {"double", 16'd0}, {"else", 32'd0},   {"enum", 32'd0},   {"extern", 16'd0},
    {"float", 24'd0},  {"for", 40'd0},    {"goto", 32'd0},   {"if", 48'd0},
    {"int", 40'd0},    {"long", 32'd0},   {"register"},      {"return", 16'd0},
    {"short", 24'd0},  {"signed", 16'd0}, {"sizeof", 16'd0}, {"static", 16'd0},
    {"struct", 16'd0}, {"switch", 16'd0}, {"typedef", 8'd0}, {"union", 24'd0},
    {"unsigned"},      {"void", 32'd0},   {"volatile"},      {"while", 24'd0}
  };

endpackage

### rtl/c_token_classifier_top.sv
// Channel  Direction  Word type    Handshake
// item     in         in_word_t    item_valid / item_stall, taken when valid and not stall
// result   out        out_word_t   result_valid / result_stall, taken when valid and not stall
//
// One text byte is taken per cycle whenever the token queue has room for two
// tokens; a byte produces zero, one or two tokens. Tokens leave at one per cycle,
// while the result port is not stalled, through the registered output stage, so
// the result port sets the rate when bytes produce more than one token each. A
// token a byte completes is written into the queue when the byte is taken and
// then popped into the registered result word; a second token from the same
// byte follows it in order. Reset is synchronous; there is no clearing pass.
// The scanner stalls only when the queue has fewer than two free slots, and the
// queue absorbs short stalls of the result port.
module c_token_classifier_top import ctc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result
);

  // The scanner front end tracks the pending word or number, splits the byte
  // stream into tokens and pushes them, in stream order, into a short queue.
  push_req_t  push;
  logic       room;
  logic       pop;
  logic       head_valid;
  lex_entry_t head;

  ctc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .room       (room),
    .item_stall (item_stall),
    .push       (push)
  );

  // The queue decouples the scanner from the output side, so a stalled
  // result port does not stop bytes from being scanned until it fills.
  ctc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end matches words against the keyword table and registers the
  // finished result word.
  ctc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

### rtl/ctc_front.sv
module ctc_front import ctc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  in_word_t  item,
  input  logic      room,
  output logic      item_stall,
  output push_req_t push
);

  scan_mode_t  mode, mode_next;
  logic [7:0]  word_prefix [MAX_KEYWORD_LEN];
  logic [7:0]  word_prefix_next [MAX_KEYWORD_LEN];
  logic [6:0]  pending_length, pending_length_next;
  logic [31:0] pending_start, pending_start_next;
  logic [7:0]  pending_first, pending_first_next;
  logic [31:0] byte_position;

  logic [7:0]          c;
  logic                accept;
  logic                is_letter, is_digit, is_oper, is_sym, high_byte;
  logic                extend_en, breaks, starts;
  scan_mode_t          mode_after;
  logic                emit_a, emit_b, emit_c;
  lex_entry_t          tok_a, tok_b, tok_c;
  logic [PREFIX_W-1:0] prefix_now, prefix_after;

  assign c          = item.text_byte;
  assign item_stall = !room;
  assign accept     = item_valid && room;

  assign high_byte = c[7];
  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit  = c >= "0" && c <= "9";
  assign is_oper   = c inside {"+", "-", "*", "/", "=", "<", ">", "%"};
  assign is_sym    = c inside {";", "{", "}", "(", ")", "[", "]", ","};

  assign extend_en = !high_byte && ((mode == MODE_WORD && (is_letter || is_digit)) ||
                                    (mode == MODE_NUM && is_digit));
  assign breaks    = !high_byte && !extend_en;
  assign starts    = breaks && (is_letter || is_digit);

  // Scan mode once the byte itself is taken in, before the end flag.
  always_comb begin
    mode_after = mode;
    if (breaks) begin
      if (is_letter) begin
        mode_after = MODE_WORD;
      end else if (is_digit) begin
        mode_after = MODE_NUM;
      end else begin
        mode_after = MODE_IDLE;
      end
    end
  end

  // Next state: the end flag flushes whatever is pending.
  always_comb begin
    mode_next = mode_after;
    if (item.end_of_text) begin
      mode_next = MODE_IDLE;
    end
  end

  // Pending token bookkeeping.
  always_comb begin
    for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
      word_prefix_next[j] = word_prefix[j];
    end
    pending_length_next = pending_length;
    pending_start_next  = pending_start;
    pending_first_next  = pending_first;
    if (extend_en) begin
      if (pending_length < 7'(MAX_KEYWORD_LEN)) begin
        word_prefix_next[pending_length[2:0]] = c;
      end
      if (pending_length < 7'(MAX_TOKEN_LEN)) begin
        pending_length_next = pending_length + 7'd1;
      end
    end else if (starts) begin
      for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
        word_prefix_next[j] = 8'd0;
      end
      word_prefix_next[0] = c;
      pending_length_next = 7'd1;
      pending_start_next  = byte_position;
      pending_first_next  = c;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
      prefix_now[(MAX_KEYWORD_LEN-1-j)*8 +: 8]   = word_prefix[j];
      prefix_after[(MAX_KEYWORD_LEN-1-j)*8 +: 8] = word_prefix_next[j];
    end
  end

  // Outputs: the ended token, then an operator or symbol, then the end flush.
  always_comb begin
    emit_a = breaks && mode != MODE_IDLE;
    emit_b = breaks && (is_oper || is_sym);
    emit_c = item.end_of_text && mode_after != MODE_IDLE;

    tok_a.kind   = (mode == MODE_WORD) ? KIND_IDENT : KIND_NUMBER;
    tok_a.length = pending_length;
    tok_a.first  = pending_first;
    tok_a.start  = pending_start;
    tok_a.last   = 1'b0;
    tok_a.prefix = prefix_now;

    tok_b.kind   = is_oper ? KIND_OPER : KIND_SYMBOL;
    tok_b.length = 7'd1;
    tok_b.first  = c;
    tok_b.start  = byte_position;
    tok_b.last   = 1'b0;
    tok_b.prefix = '0;

    tok_c.kind   = (mode_after == MODE_WORD) ? KIND_IDENT : KIND_NUMBER;
    tok_c.length = pending_length_next;
    tok_c.first  = pending_first_next;
    tok_c.start  = pending_start_next;
    tok_c.last   = 1'b0;
    tok_c.prefix = prefix_after;

    push.count  = accept ? (2'(emit_a) + 2'(emit_b) + 2'(emit_c)) : 2'd0;
    push.first  = emit_a ? tok_a : (emit_b ? tok_b : tok_c);
    push.second = emit_b ? tok_b : tok_c;
    push.first.last  = (push.count == 2'd1);
    push.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      byte_position <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      byte_position <= byte_position + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
        word_prefix[j] <= 8'd0;
      end
      pending_length <= '0;
      pending_start  <= '0;
      pending_first  <= '0;
    end else if (accept) begin
      for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
        word_prefix[j] <= word_prefix_next[j];
      end
      pending_length <= pending_length_next;
      pending_start  <= pending_start_next;
      pending_first  <= pending_first_next;
    end
  end

  a_end_flushes: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_text) |=> (mode == MODE_IDLE))
    else $error("scanner kept a pending token after the end flag");

endmodule

### rtl/ctc_queue.sv
module ctc_queue import ctc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_req_t  push,
  input  logic       pop,
  output logic       room,
  output logic       head_valid,
  output lex_entry_t head
);

  lex_entry_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  // Room is kept for the worst case of two tokens from one byte.
  assign room       = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= QCNT_W'(QUEUE_DEPTH - 2)))
    else $error("token pushed into a queue without room for two");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("token popped from an empty queue");

endmodule

### rtl/ctc_back.sv
module ctc_back import ctc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  lex_entry_t head,
  output logic       pop,
  input  logic       result_stall,
  output logic       result_valid,
  output out_word_t  result
);

  logic [KEYWORD_SLOTS-1:0] hit;
  logic                     is_keyword;
  logic [4:0]               kw_index;
  out_word_t                shaped;

  // All keyword slots are compared at once against the word prefix.
  always_comb begin
    for (int i = 0; i < KEYWORD_SLOTS; i++) begin
      hit[i] = head.prefix == KEYWORD_TEXT[i];
    end
  end

  always_comb begin
    kw_index = '0;
    for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        kw_index = 5'(i);
      end
    end
  end

  assign is_keyword = head.kind == KIND_IDENT && head.length <= 7'(MAX_KEYWORD_LEN) &&
                      hit != '0;

  always_comb begin
    shaped.token_kind     = is_keyword ? KIND_KEYWORD : head.kind;
    shaped.keyword_number = is_keyword ? kw_index : 5'd0;
    shaped.token_length   = head.length;
    shaped.token_byte     = head.first;
    shaped.start_offset   = head.start;
    shaped.last_of_run    = head.last;
  end

  assign pop = head_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= shaped;
    end
  end

  a_keyword_length: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.token_kind == KIND_KEYWORD) |->
      (result.token_length >= 7'd2 && result.token_length <= 7'(MAX_KEYWORD_LEN)))
    else $error("keyword reported with an impossible length");

  a_index_only_for_keyword: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.token_kind != KIND_KEYWORD) |-> (result.keyword_number == 5'd0))
    else $error("keyword index set on a token that is not a keyword");

endmodule
